// File: rtl/tsm_pkg.sv
// shared types and constants of the timestamp result matcher
`timescale 1ns / 1ps
package tsm_pkg;

   localparam int STAMP_W     = 48;
   localparam int TAG_W       = 16;
   localparam int LIMIT_W     = 5;
   localparam int TIMEOUT_W   = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_RESULTS = 16;
   localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

   localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 5'd16;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

   typedef enum logic [0:0] {
      OP_FRAME  = 1'b0,
      OP_RESULT = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_TABLE_LIMIT = 1'b0,
      CSR_TIMEOUT     = 1'b1
   } csr_index_type;

   // what every cell of a row does at a clock edge
   typedef enum logic [1:0] {
      ROW_HOLD   = 2'd0,
      ROW_LOOKUP = 2'd1,
      ROW_INSERT = 2'd2,
      ROW_POP    = 2'd3
   } row_op_type;

   typedef struct packed {
      row_op_type op;
      logic       dup_any;
   } cell_ctl_type;

   typedef struct packed {
      op_type             op;
      logic [STAMP_W-1:0] stamp_ms;
      logic [TAG_W-1:0]   result_tag;
   } req_type;

   typedef struct packed {
      logic [STAMP_W-1:0] match_stamp;
      logic [TAG_W-1:0]   match_tag;
      logic               is_last;
   } rsp_type;

endpackage

// File: rtl/tsm_cell.sv
// one cell of a sorted timestamp row
`timescale 1ns / 1ps
module tsm_cell #(
   parameter int PAY_W = 16
) (
   input  logic                         clock,
   input  tsm_pkg::cell_ctl_type        ctl,
   input  logic                         valid_self,
   input  logic [tsm_pkg::STAMP_W-1:0]  new_key,
   input  logic [PAY_W-1:0]             new_pay,
   input  logic                         lt_left,
   input  logic [tsm_pkg::STAMP_W-1:0]  left_key,
   input  logic [PAY_W-1:0]             left_pay,
   input  logic [tsm_pkg::STAMP_W-1:0]  right_key,
   input  logic [PAY_W-1:0]             right_pay,
   output logic [tsm_pkg::STAMP_W-1:0]  key,
   output logic [PAY_W-1:0]             pay,
   output logic                         lt,
   output logic                         dup_here
);
   import tsm_pkg::*;

   logic [STAMP_W-1:0] key_ff, key_in;
   logic [PAY_W-1:0]   pay_ff, pay_in;
   logic               lt_ff, lt_in;
   logic               eq_ff, eq_in;
   logic               at_pos;

   // first cell whose key is not below the new key
   assign at_pos   = !lt_ff && lt_left;
   assign dup_here = at_pos && eq_ff;

   always_comb begin
      key_in = key_ff;
      pay_in = pay_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      case (ctl.op)
         ROW_LOOKUP: begin
            lt_in = valid_self && (key_ff < new_key);
            eq_in = valid_self && (key_ff == new_key);
         end
         ROW_INSERT: begin
            if (ctl.dup_any) begin
               if (dup_here) begin
                  pay_in = new_pay;
               end
            end else if (!lt_ff) begin
               if (lt_left) begin
                  key_in = new_key;
                  pay_in = new_pay;
               end else begin
                  key_in = left_key;
                  pay_in = left_pay;
               end
            end
         end
         ROW_POP: begin
            key_in = right_key;
            pay_in = right_pay;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pay_ff <= pay_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key = key_ff;
   assign pay = pay_ff;
   assign lt  = lt_ff;

endmodule

// File: rtl/tsm_row.sv
// sorted row of cells with its fill count
`timescale 1ns / 1ps
module tsm_row #(
   parameter int DEPTH = 16,
   parameter int PAY_W = 16,
   localparam int CW   = $clog2(DEPTH + 2)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tsm_pkg::row_op_type          op,
   input  logic [tsm_pkg::STAMP_W-1:0]  new_key,
   input  logic [PAY_W-1:0]             new_pay,
   output logic [CW-1:0]                count,
   output logic [tsm_pkg::STAMP_W-1:0]  head_key,
   output logic [PAY_W-1:0]             head_pay
);
   import tsm_pkg::*;

   // one spare cell holds the entry that an insert pushes past the limit
   localparam int N = DEPTH + 1;

   logic [STAMP_W-1:0] key_w [N];
   logic [PAY_W-1:0]   pay_w [N];
   logic [N-1:0]       lt_w;
   logic [N-1:0]       dup_w;
   logic               dup_any;
   cell_ctl_type       ctl;
   logic [CW-1:0]      count_ff, count_in;

   assign dup_any     = |dup_w;
   assign ctl.op      = op;
   assign ctl.dup_any = dup_any;

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                lt_left;
      logic [STAMP_W-1:0]  left_key, right_key;
      logic [PAY_W-1:0]    left_pay, right_pay;

      if (i == 0) begin : g_first
         assign lt_left  = 1'b1;
         assign left_key = new_key;
         assign left_pay = new_pay;
      end else begin : g_inner_l
         assign lt_left  = lt_w[i-1];
         assign left_key = key_w[i-1];
         assign left_pay = pay_w[i-1];
      end

      if (i == N - 1) begin : g_last
         assign right_key = key_w[i];
         assign right_pay = pay_w[i];
      end else begin : g_inner_r
         assign right_key = key_w[i+1];
         assign right_pay = pay_w[i+1];
      end

      tsm_cell #(
         .PAY_W(PAY_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .valid_self(CW'(i) < count_ff),
         .new_key   (new_key),
         .new_pay   (new_pay),
         .lt_left   (lt_left),
         .left_key  (left_key),
         .left_pay  (left_pay),
         .right_key (right_key),
         .right_pay (right_pay),
         .key       (key_w[i]),
         .pay       (pay_w[i]),
         .lt        (lt_w[i]),
         .dup_here  (dup_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      case (op)
         ROW_INSERT: begin
            if (!dup_any) begin
               count_in = count_ff + CW'(1);
            end
         end
         ROW_POP: begin
            if (count_ff != '0) begin
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count    = count_ff;
   assign head_key = key_w[0];
   assign head_pay = pay_w[0];

endmodule

// File: rtl/timestamp_result_matcher.sv
// top level: frame and result rows with the insert, evict and head matching sequencer
`timescale 1ns / 1ps
// frame request: busy through the insert and evict states; a new request is taken only back in idle
// result request: busy through insert, evict, R match rounds (R at most the result count) and flush
// matches leave at most one per round, each held as pending until the next match, the last one sent from flush
// each step is one operation of the cell rows; one 48-bit head compare per round sets the pace
// synchronous reset empties both rows at once (counts to zero), limit 16, timeout 1000 ms
module timestamp_result_matcher #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          start,
   output logic                          busy,
   input  tsm_pkg::req_type              req_data,
   // result side
   output logic                          rsp_strobe,
   output tsm_pkg::rsp_type              rsp_data,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  tsm_pkg::csr_index_type        csr_index,
   input  logic [tsm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tsm_pkg::*;

   localparam int CW = $clog2(DEPTH + 2);
   localparam int EW = (CW > LIMIT_W) ? CW : LIMIT_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_INSERT = 5'b00010,
      ST_EVICT  = 5'b00100,
      ST_MATCH  = 5'b01000,
      ST_FLUSH  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   req_type               item_ff, item_in;
   logic [CW-1:0]         round_ff, round_in;
   logic [EMIT_W-1:0]     emit_ff, emit_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [STAMP_W-1:0]    pend_stamp_ff, pend_stamp_in;
   logic [TAG_W-1:0]      pend_tag_ff, pend_tag_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [TIMEOUT_W-1:0]  timeout_ff, timeout_in;

   // row interfaces
   row_op_type            frame_op, result_op;
   logic [STAMP_W-1:0]    key_bus;
   logic [CW-1:0]         f_count, r_count;
   logic [STAMP_W-1:0]    f_head, r_head;
   logic [TAG_W-1:0]      r_tag;

   // head comparison
   logic [CW-1:0]         eff_limit;
   logic [STAMP_W-1:0]    timeout_ext;
   logic                  heads_eq, r_newer, drop_f, drop_r, go;
   logic [STAMP_W-1:0]    diff_rf, diff_fr;
   logic                  accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // a limit of zero acts as one, above the row depth as the depth
   always_comb begin
      if (limit_ff == '0) begin
         eff_limit = CW'(1);
      end else if (EW'(limit_ff) > EW'(DEPTH)) begin
         eff_limit = CW'(DEPTH);
      end else begin
         eff_limit = CW'(limit_ff);
      end
   end

   assign timeout_ext = STAMP_W'(timeout_ff);
   assign heads_eq    = (f_head == r_head);
   assign r_newer     = (r_head > f_head);
   assign diff_rf     = r_head - f_head;
   assign diff_fr     = f_head - r_head;
   assign drop_f      = r_newer && (diff_rf > timeout_ext);
   assign drop_r      = !heads_eq && !r_newer && (diff_fr > timeout_ext);
   assign go          = (round_ff != '0) && (f_count != '0) && (r_count != '0);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      round_in      = round_ff;
      emit_in       = emit_ff;
      pend_valid_in = pend_valid_ff;
      pend_stamp_in = pend_stamp_ff;
      pend_tag_in   = pend_tag_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      frame_op      = ROW_HOLD;
      result_op     = ROW_HOLD;
      key_bus       = item_ff.stamp_ms;

      case (state_ff)
         ST_IDLE: begin
            // both rows look up the new stamp while the request is taken
            key_bus = req_data.stamp_ms;
            if (accept) begin
               frame_op      = ROW_LOOKUP;
               result_op     = ROW_LOOKUP;
               item_in       = req_data;
               pend_valid_in = 1'b0;
               emit_in       = '0;
               state_in      = ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (item_ff.op == OP_FRAME) begin
               frame_op = ROW_INSERT;
            end else begin
               result_op = ROW_INSERT;
            end
            state_in = ST_EVICT;
         end
         ST_EVICT: begin
            if (item_ff.op == OP_FRAME) begin
               if (f_count > eff_limit) begin
                  frame_op = ROW_POP;
               end
               state_in = ST_IDLE;
            end else begin
               // round budget is the result count once eviction is done
               if (r_count > eff_limit) begin
                  result_op = ROW_POP;
                  round_in  = r_count - CW'(1);
               end else begin
                  round_in  = r_count;
               end
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (!go) begin
               state_in = ST_FLUSH;
            end else begin
               round_in = round_ff - CW'(1);
               if (heads_eq) begin
                  frame_op  = ROW_POP;
                  result_op = ROW_POP;
                  if (emit_ff < EMIT_W'(MAX_RESULTS)) begin
                     // previous match goes out, this one waits to learn if it is last
                     if (pend_valid_ff) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_in.match_stamp = pend_stamp_ff;
                        rsp_in.match_tag   = pend_tag_ff;
                        rsp_in.is_last     = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_stamp_in = r_head;
                     pend_tag_in   = r_tag;
                     emit_in       = emit_ff + EMIT_W'(1);
                  end
               end else if (drop_f) begin
                  frame_op = ROW_POP;
               end else if (drop_r) begin
                  result_op = ROW_POP;
               end else begin
                  // heads within the timeout: nothing changes, stop
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.match_stamp = pend_stamp_ff;
               rsp_in.match_tag   = pend_tag_ff;
               rsp_in.is_last     = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // register writes
   always_comb begin
      limit_in   = limit_ff;
      timeout_in = timeout_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TABLE_LIMIT: limit_in   = csr_wdata[LIMIT_W-1:0];
            CSR_TIMEOUT:     timeout_in = csr_wdata[TIMEOUT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         round_ff      <= '0;
         emit_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         limit_ff      <= LIMIT_RESET;
         timeout_ff    <= TIMEOUT_RESET;
      end else begin
         state_ff      <= state_in;
         round_ff      <= round_in;
         emit_ff       <= emit_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         limit_ff      <= limit_in;
         timeout_ff    <= timeout_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      pend_stamp_ff <= pend_stamp_in;
      pend_tag_ff   <= pend_tag_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // frame times row, no payload
   tsm_row #(
      .DEPTH(DEPTH),
      .PAY_W(1)
   ) u_frame_row (
      .clock   (clock),
      .reset   (reset),
      .op      (frame_op),
      .new_key (key_bus),
      .new_pay (1'b0),
      .count   (f_count),
      .head_key(f_head),
      .head_pay()
   );

   // result times row carrying tags
   tsm_row #(
      .DEPTH(DEPTH),
      .PAY_W(TAG_W)
   ) u_result_row (
      .clock   (clock),
      .reset   (reset),
      .op      (result_op),
      .new_key (key_bus),
      .new_pay (item_ff.result_tag),
      .count   (r_count),
      .head_key(r_head),
      .head_pay(r_tag)
   );

endmodule

// File: rtl/tsm_checker.sv
// port-level checks of the timestamp result matcher and their bind
`timescale 1ns / 1ps
module tsm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input tsm_pkg::req_type               req_data,
   input logic                           rsp_strobe,
   input tsm_pkg::rsp_type               rsp_data
);
   import tsm_pkg::*;

   // a frame request keeps the block busy through insert and evict, then idle
   a_frame_timing: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.op == OP_FRAME) |=> busy ##1 busy ##1 !busy)
      else $error("frame request timing wrong");

   // a frame request never produces a result
   a_frame_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.op == OP_FRAME) |=> !rsp_strobe ##1 !rsp_strobe ##1 !rsp_strobe)
      else $error("result after frame request");

   // the last result of a request is alone and the block is then idle
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.is_last |-> !busy ##1 !rsp_strobe)
      else $error("activity after last result");

   // idle without a request stays idle
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !busy && !rsp_strobe)
      else $error("block woke without a request");

endmodule

bind timestamp_result_matcher tsm_checker u_tsm_checker (.*);
